>>> rtl/ffpa_pkg.sv
`timescale 1ns / 1ps

package ffpa_pkg;

   localparam int unsigned MaxSegmentsDefault   = 64;
   localparam int unsigned PageIndexBitsDefault = 20;
   localparam int unsigned CfgWidth             = 21;
   localparam int unsigned CsrAddrWidth         = 3;
   localparam int unsigned CsrDataWidth         = 32;
   localparam int unsigned PageShift            = 12;

   localparam logic [CfgWidth-1:0] TotalPagesReset    = 21'd4096;
   localparam logic [CfgWidth-1:0] ReservedPagesReset = 21'd256;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_NO_SPACE     = 3'd1,
      STATUS_TABLE_FULL   = 3'd2,
      STATUS_NOT_FOUND    = 3'd3,
      STATUS_ALREADY_FREE = 3'd4,
      STATUS_BAD_REQUEST  = 3'd5
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_TOTAL_PAGES    = 1'b0,
      REG_RESERVED_PAGES = 1'b1
   } csr_reg_type;

   typedef enum logic [4:0] {
      S_BUILD0,
      S_BUILD1,
      S_IDLE,
      S_FIT_RD,
      S_FIT_CHK,
      S_MRG_RD,
      S_MRG_CHK,
      S_MRG_END,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SPLIT_WR,
      S_GRANT_WR,
      S_FREE_RD,
      S_FREE_CHK,
      S_DONE
   } state_type;

   // Configuration handed from the register file to the sequencer.
   typedef struct packed {
      logic                rebuild;
      logic [CfgWidth-1:0] total;
      logic [CfgWidth-1:0] reserved;
   } cfg_type;

endpackage

>>> rtl/ffpa_seg_mem.sv
`timescale 1ns / 1ps

module ffpa_seg_mem #(
   parameter int unsigned Depth = 64,
   parameter int unsigned Width = 42
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ffpa_ctrl.sv
`timescale 1ns / 1ps

module ffpa_ctrl #(
   parameter int unsigned MaxSegments   = 64,
   parameter int unsigned PageIndexBits = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ffpa_pkg::cfg_type         cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [PageIndexBits:0]    req_count,
   input  logic [PageIndexBits-1:0]  req_page,
   input  logic                      req_skip,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [PageIndexBits-1:0]  rsp_granted,
   output logic [PageIndexBits:0]    rsp_free
);
   import ffpa_pkg::*;

   localparam int unsigned P  = PageIndexBits;
   localparam int unsigned AW = $clog2(MaxSegments);
   localparam int unsigned IW = AW + 1;
   localparam int unsigned LW = P + 1;
   localparam int unsigned EW = 2 * P + 2;
   localparam int unsigned MW = (CfgWidth > LW) ? CfgWidth : LW;

   state_type        state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    wptr_ff, wptr_in;
   logic [IW-1:0]    total_ff, total_in;
   logic [IW-1:0]    hidx_ff, hidx_in;
   logic [EW-1:0]    cur_ff, cur_in;
   logic [EW-1:0]    hit_ff, hit_in;
   logic             op_ff, op_in;
   logic [LW-1:0]    count_ff, count_in;
   logic [P-1:0]     page_ff, page_in;
   logic             skip_ff, skip_in;
   logic             merged_ff, merged_in;
   status_type       status_ff, status_in;
   logic [P-1:0]     granted_ff, granted_in;
   logic [LW-1:0]    free_ff, free_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [P-1:0]     rsp_granted_ff, rsp_granted_in;
   logic [LW-1:0]    rsp_free_ff, rsp_free_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;
   logic [EW-1:0]    rd_data;

   logic             e_used;
   logic [LW-1:0]    e_len;
   logic [P-1:0]     e_start;
   logic [IW-1:0]    idx_next;
   logic             idx_last;
   logic [MW-1:0]    lim_ext, tot_ext, res_ext, tot_c, res_c;
   logic [LW-1:0]    tot_w, res_w;

   ffpa_seg_mem #(
      .Depth (MaxSegments),
      .Width (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Entry layout from the low bit up: start, length, used.
   assign e_start  = rd_data[P-1:0];
   assign e_len    = rd_data[2*P:P];
   assign e_used   = rd_data[EW-1];
   assign idx_next = idx_ff + 1'b1;
   assign idx_last = (idx_next == total_ff);

   assign lim_ext = MW'(1) << P;
   assign tot_ext = MW'(cfg.total);
   assign res_ext = MW'(cfg.reserved);
   assign tot_c   = (tot_ext < lim_ext) ? tot_ext : lim_ext;
   assign res_c   = (res_ext < tot_c) ? res_ext : tot_c;
   assign tot_w   = tot_c[LW-1:0];
   assign res_w   = res_c[LW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BUILD0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      wptr_ff        <= wptr_in;
      total_ff       <= total_in;
      hidx_ff        <= hidx_in;
      cur_ff         <= cur_in;
      hit_ff         <= hit_in;
      op_ff          <= op_in;
      count_ff       <= count_in;
      page_ff        <= page_in;
      skip_ff        <= skip_in;
      merged_ff      <= merged_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      free_ff        <= free_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      wptr_in        = wptr_ff;
      total_in       = total_ff;
      hidx_in        = hidx_ff;
      cur_in         = cur_ff;
      hit_in         = hit_ff;
      op_in          = op_ff;
      count_in       = count_ff;
      page_in        = page_ff;
      skip_in        = skip_ff;
      merged_in      = merged_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      free_in        = free_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_free_in    = rsp_free_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff[AW-1:0];
      wr_data        = rd_data;
      req_ready      = 1'b0;

      unique case (state_ff)
         S_BUILD0: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {1'b1, res_w, {P{1'b0}}};
            state_in = S_BUILD1;
         end
         S_BUILD1: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(1);
            wr_data  = {1'b0, tot_w - res_w, res_w[P-1:0]};
            total_in = IW'(2);
            free_in  = tot_w - res_w;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = req_op;
               count_in   = req_count;
               page_in    = req_page;
               skip_in    = req_skip;
               merged_in  = 1'b0;
               granted_in = '0;
               idx_in     = '0;
               if (req_op == OP_FREE) begin
                  state_in = S_FREE_RD;
               end else if (req_count == '0) begin
                  status_in = STATUS_BAD_REQUEST;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_FIT_RD;
               end
            end
         end
         S_FIT_RD: begin
            state_in = S_FIT_CHK;
         end
         S_FIT_CHK: begin
            if (!e_used && e_len >= count_ff) begin
               hit_in  = rd_data;
               hidx_in = idx_ff;
               if (e_len == count_ff) begin
                  state_in = S_GRANT_WR;
               end else if (total_ff == IW'(MaxSegments)) begin
                  status_in = STATUS_TABLE_FULL;
                  state_in  = S_DONE;
               end else if (idx_last) begin
                  state_in = S_SPLIT_WR;
               end else begin
                  idx_in   = total_ff - 1'b1;
                  state_in = S_SHIFT_RD;
               end
            end else if (idx_last) begin
               if (!skip_ff && !merged_ff) begin
                  merged_in = 1'b1;
                  idx_in    = '0;
                  wptr_in   = '0;
                  state_in  = S_MRG_RD;
               end else begin
                  status_in = STATUS_NO_SPACE;
                  state_in  = S_DONE;
               end
            end else begin
               idx_in   = idx_next;
               state_in = S_FIT_RD;
            end
         end
         S_MRG_RD: begin
            state_in = S_MRG_CHK;
         end
         S_MRG_CHK: begin
            if (idx_ff == '0) begin
               cur_in = rd_data;
            end else if (!cur_ff[EW-1] && !e_used) begin
               cur_in[2*P:P] = cur_ff[2*P:P] + e_len;
            end else begin
               wr_en   = 1'b1;
               wr_addr = wptr_ff[AW-1:0];
               wr_data = cur_ff;
               wptr_in = wptr_ff + 1'b1;
               cur_in  = rd_data;
            end
            idx_in   = idx_next;
            state_in = idx_last ? S_MRG_END : S_MRG_RD;
         end
         S_MRG_END: begin
            wr_en    = 1'b1;
            wr_addr  = wptr_ff[AW-1:0];
            wr_data  = cur_ff;
            total_in = wptr_ff + 1'b1;
            idx_in   = '0;
            state_in = S_FIT_RD;
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_next[AW-1:0];
            wr_data = rd_data;
            if (idx_ff == hidx_ff + 1'b1) begin
               state_in = S_SPLIT_WR;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_SHIFT_RD;
            end
         end
         S_SPLIT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(hidx_ff + 1'b1);
            wr_data  = {1'b0, hit_ff[2*P:P] - count_ff, hit_ff[P-1:0] + count_ff[P-1:0]};
            total_in = total_ff + 1'b1;
            state_in = S_GRANT_WR;
         end
         S_GRANT_WR: begin
            wr_en      = 1'b1;
            wr_addr    = hidx_ff[AW-1:0];
            wr_data    = {1'b1, count_ff, hit_ff[P-1:0]};
            free_in    = free_ff - count_ff;
            granted_in = hit_ff[P-1:0];
            status_in  = STATUS_OK;
            state_in   = S_DONE;
         end
         S_FREE_RD: begin
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (e_start == page_ff) begin
               if (e_used) begin
                  wr_en     = 1'b1;
                  wr_data   = {1'b0, e_len, e_start};
                  free_in   = free_ff + e_len;
                  status_in = STATUS_OK;
               end else begin
                  status_in = STATUS_ALREADY_FREE;
               end
               state_in = S_DONE;
            end else if (idx_last) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               idx_in   = idx_next;
               state_in = S_FREE_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = granted_ff;
               rsp_free_in    = free_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_BUILD0;
         end
      endcase

      if (cfg.rebuild) begin
         state_in = S_BUILD0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_free    = rsp_free_ff;

endmodule

>>> rtl/first_fit_page_allocator.sv
`timescale 1ns / 1ps
// An allocate scans the segment table for the first free segment that is large enough; if
// none fits and skip_merge is clear, free neighbours are coalesced and the table is scanned
// again; a split moves the later entries up. A free scans for the segment at the given page.
// One request at a time. Reset (synchronous, active high) restores the register defaults
// and rebuilds the table; a configuration write rebuilds it in the same way.

module first_fit_page_allocator #(
   parameter int unsigned MaxSegments   = ffpa_pkg::MaxSegmentsDefault,
   parameter int unsigned PageIndexBits = ffpa_pkg::PageIndexBitsDefault
) (
   input  logic clock,
   input  logic reset,
   // Request channel.
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // tdata, from bit 0 up: page_count, page, skip_merge, zero fill.
   input  logic [((2*PageIndexBits+2+7)/8)*8-1:0]     req_tdata,
   // tuser: opcode.
   input  logic                                       req_tuser,
   // Result channel.
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // tdata, from bit 0 up: granted_page, free_page_total, zero fill.
   output logic [((2*PageIndexBits+1+7)/8)*8-1:0]     rsp_tdata,
   // tuser: status.
   output logic [2:0]                                 rsp_tuser,
   // Register port.
   input  logic                                       csr_psel,
   input  logic                                       csr_penable,
   input  logic                                       csr_pwrite,
   input  logic [ffpa_pkg::CsrAddrWidth-1:0]          csr_paddr,
   input  logic [ffpa_pkg::CsrDataWidth-1:0]          csr_pwdata,
   output logic [ffpa_pkg::CsrDataWidth-1:0]          csr_prdata,
   output logic                                       csr_pready
);
   import ffpa_pkg::*;

   localparam int unsigned P      = PageIndexBits;
   localparam int unsigned RspW   = ((2 * P + 1 + 7) / 8) * 8;

   logic [CfgWidth-1:0] total_ff, total_in;
   logic [CfgWidth-1:0] reserved_ff, reserved_in;
   logic                csr_write;
   csr_reg_type         csr_sel;
   cfg_type             cfg;
   logic [P-1:0]        rsp_granted;
   logic [P:0]          rsp_free;

   // A register write completes in the access cycle; pready is tied high, so every access
   // is a single-wait-free transfer. Byte address bit 2 selects the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      total_in    = total_ff;
      reserved_in = reserved_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_TOTAL_PAGES:    total_in    = csr_pwdata[CfgWidth-1:0];
            REG_RESERVED_PAGES: reserved_in = csr_pwdata[CfgWidth-1:0];
            default:            total_in    = total_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= TotalPagesReset;
         reserved_ff <= ReservedPagesReset;
      end else begin
         total_ff    <= total_in;
         reserved_ff <= reserved_in;
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_TOTAL_PAGES:    csr_prdata = CsrDataWidth'(total_ff);
         REG_RESERVED_PAGES: csr_prdata = CsrDataWidth'(reserved_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // The sequencer gets the new register values in the write cycle and starts to rebuild
   // the table from them in the cycle after it.
   assign cfg.rebuild  = csr_write;
   assign cfg.total    = total_in;
   assign cfg.reserved = reserved_in;

   ffpa_ctrl #(
      .MaxSegments   (MaxSegments),
      .PageIndexBits (PageIndexBits)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_count   (req_tdata[P:0]),
      .req_page    (req_tdata[2*P:P+1]),
      .req_skip    (req_tdata[2*P+1]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_granted (rsp_granted),
      .rsp_free    (rsp_free)
   );

   // Result payload packs granted page and free page total; the pad bits are zero.
   assign rsp_tdata = RspW'({rsp_free, rsp_granted});

endmodule

>>> rtl/ffpa_checker.sv
`timescale 1ns / 1ps

module ffpa_port_checks #(
   parameter int unsigned PageIndexBits = 20
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tvalid,
   input logic                                   req_tready,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [((2*PageIndexBits+1+7)/8)*8-1:0] rsp_tdata,
   input logic [2:0]                             rsp_tuser,
   input logic                                   csr_psel,
   input logic                                   csr_penable,
   input logic                                   csr_pwrite
);

   localparam int unsigned P = PageIndexBits;

   // A held result keeps its payload until the transfer completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A request keeps the block busy, so it cannot take another at once.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A register write rebuilds the table, so no request is taken right after it.
   a_cfg_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=> !req_tready)
      else $error("request taken during rebuild");

   // The free page total never exceeds the managed range.
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2*P:P] <= (P+1)'(1) << P)
      else $error("free page total out of range");

endmodule

bind first_fit_page_allocator ffpa_port_checks #(
   .PageIndexBits (PageIndexBits)
) u_ffpa_port_checks (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite)
);

>>> tb/sv/ffpa_checker.sv
`timescale 1ns / 1ps

module ffpa_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   import ffpa_pkg::*;

   localparam int Depth = 64;

   typedef struct {
      status_type  status;
      logic [19:0] granted;
      logic [20:0] free_total;
   } outcome_type;

   logic [20:0] cfg_total;
   logic [20:0] cfg_reserved;
   logic [20:0] seg_base [Depth];
   logic [20:0] seg_pages [Depth];
   bit          seg_taken [Depth];
   int          seg_count;
   logic [20:0] free_left;
   outcome_type outcome_queue [$];

   initial fail_count = 0;
   assign pending = outcome_queue.size();

   function automatic void rebuild_table();
      logic [20:0] tot;
      logic [20:0] res;
      tot = (cfg_total < 21'h100000) ? cfg_total : 21'h100000;
      res = (cfg_reserved < tot) ? cfg_reserved : tot;
      for (int k = 0; k < Depth; k++) begin
         seg_base[k] = '0;
         seg_pages[k] = '0;
         seg_taken[k] = 0;
      end
      seg_pages[0] = res;
      seg_taken[0] = 1;
      seg_base[1] = res;
      seg_pages[1] = tot - res;
      seg_count = 2;
      free_left = tot - res;
   endfunction

   function automatic int find_fit(logic [20:0] want);
      for (int k = 0; k < seg_count; k++)
         if (!seg_taken[k] && seg_pages[k] >= want) return k;
      return -1;
   endfunction

   // Folds every run of neighboring free segments into its first entry.
   function automatic void merge_free_runs();
      int k;
      k = 0;
      while (k + 1 < seg_count) begin
         if (!seg_taken[k] && !seg_taken[k+1]) begin
            seg_pages[k] = seg_pages[k] + seg_pages[k+1];
            for (int m = k + 1; m < seg_count - 1; m++) begin
               seg_base[m] = seg_base[m+1];
               seg_pages[m] = seg_pages[m+1];
               seg_taken[m] = seg_taken[m+1];
            end
            seg_count--;
            seg_base[seg_count] = '0;
            seg_pages[seg_count] = '0;
            seg_taken[seg_count] = 0;
         end else begin
            k++;
         end
      end
   endfunction

   function automatic outcome_type grant_pages(logic [20:0] want, bit skip);
      outcome_type o;
      int k;
      o.status = STATUS_OK;
      o.granted = '0;
      if (want == 0) begin
         o.status = STATUS_BAD_REQUEST;
      end else begin
         k = find_fit(want);
         if (k < 0 && !skip) begin
            merge_free_runs();
            k = find_fit(want);
         end
         if (k < 0) begin
            o.status = STATUS_NO_SPACE;
         end else if (seg_pages[k] != want && seg_count >= Depth) begin
            o.status = STATUS_TABLE_FULL;
         end else begin
            if (seg_pages[k] != want) begin
               for (int m = seg_count - 1; m > k; m--) begin
                  seg_base[m+1] = seg_base[m];
                  seg_pages[m+1] = seg_pages[m];
                  seg_taken[m+1] = seg_taken[m];
               end
               seg_base[k+1] = seg_base[k] + want;
               seg_pages[k+1] = seg_pages[k] - want;
               seg_taken[k+1] = 0;
               seg_pages[k] = want;
               seg_count++;
            end
            seg_taken[k] = 1;
            free_left = free_left - want;
            o.granted = seg_base[k][19:0];
         end
      end
      o.free_total = free_left;
      return o;
   endfunction

   function automatic outcome_type release_pages(logic [19:0] page);
      outcome_type o;
      int k;
      o.granted = '0;
      k = -1;
      for (int m = 0; m < seg_count && k < 0; m++)
         if (seg_base[m] == {1'b0, page}) k = m;
      if (k < 0) begin
         o.status = STATUS_NOT_FOUND;
      end else if (!seg_taken[k]) begin
         o.status = STATUS_ALREADY_FREE;
      end else begin
         seg_taken[k] = 0;
         free_left = free_left + seg_pages[k];
         o.status = STATUS_OK;
      end
      o.free_total = free_left;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         cfg_total = TotalPagesReset;
         cfg_reserved = ReservedPagesReset;
         rebuild_table();
         outcome_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_RESERVED_PAGES) cfg_reserved = csr_pwdata[20:0];
            else cfg_total = csr_pwdata[20:0];
            rebuild_table();
         end
         // Results are handled before new requests so that a queue that is empty
         // at this edge never hands a fresh expectation to an older result.
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_queue.size() == 0) begin
               $error("unexpected result transfer: status %0d", rsp_tuser);
               fail_count++;
            end else begin
               o = outcome_queue.pop_front();
               if (rsp_tuser != o.status) begin
                  $error("status: expected %0d, actual %0d", o.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[19:0] != o.granted) begin
                  $error("granted_page: expected %0d, actual %0d", o.granted, rsp_tdata[19:0]);
                  fail_count++;
               end
               if (rsp_tdata[40:20] != o.free_total) begin
                  $error("free_page_total: expected %0d, actual %0d",
                         o.free_total, rsp_tdata[40:20]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_ALLOC) o = grant_pages(req_tdata[20:0], req_tdata[41]);
            else o = release_pages(req_tdata[40:21]);
            outcome_queue.push_back(o);
         end
      end
   end

endmodule

>>> tb/sv/first_fit_page_allocator_tb.sv
`timescale 1ns / 1ps

module first_fit_page_allocator_tb;
   import ffpa_pkg::*;

   // Even a scan with a coalesce pass over a full table ends long before this
   // limit, so reaching it can only mean a hang.
   localparam int StallLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata, from bit 0 up: page_count, page, skip_merge, zero fill.
   logic [47:0] req_tdata = '0;
   // req_tuser: opcode.
   logic        req_tuser = OP_ALLOC;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata, from bit 0 up: granted_page, free_page_total, zero fill.
   logic [47:0] rsp_tdata;
   // rsp_tuser: status.
   logic [2:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          pending;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   // Pages handed out and not yet returned; frees mostly pick from here.
   logic [19:0] live_pages [$];
   opcode_type  op_in_flight [$];
   logic [15:0] stall_lfsr = 16'hACE1;
   logic [1:0]  stall_mode = 2'd0;
   int          stall_timer = 0;

   always #10 clock = ~clock;

   first_fit_page_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   ffpa_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending)
   );

   // The result side stalls on its own pattern: whenever stall_timer runs out it picks a mode,
   // from always ready to ready only one cycle in four.
   always @(posedge clock) begin
      stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12]
                     ^ stall_lfsr[10]};
      if (stall_timer == 0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         stall_timer <= 63;
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= stall_lfsr[0];
         2'd2: rsp_tready <= stall_lfsr[1:0] == 2'b00;
         default: rsp_tready <= stall_lfsr[1:0] != 2'b00;
      endcase
   end

   // Granted pages are learned from result transfers; the opcode of each request
   // is kept so that a successful free is not mistaken for a grant.
   always @(posedge clock) begin
      opcode_type op;
      if (!reset && rsp_tvalid && rsp_tready && op_in_flight.size() != 0) begin
         op = op_in_flight.pop_front();
         if (op == OP_ALLOC && rsp_tuser == STATUS_OK) live_pages.push_back(rsp_tdata[19:0]);
      end
      if (!reset && req_tvalid && req_tready) op_in_flight.push_back(opcode_type'(req_tuser));
   end

   // Watchdog: any transfer on either channel or the register port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one request and holds it until the transfer. The valid stays high
   // afterwards so that back-to-back requests need no extra edge.
   task automatic send_request(opcode_type op, logic [20:0] count, logic [19:0] page, bit skip);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'b0, skip, page, count};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Between bursts the sender goes quiet for a random stretch; some bursts are long
   // and have no gap at all, so the block also sees requests back to back.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 6);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_pool(logic [31:0] total, logic [31:0] reserved);
      drain();
      write_reg(REG_TOTAL_PAGES, total);
      write_reg(REG_RESERVED_PAGES, reserved);
      live_pages.delete();
   endtask

   // One random request. Most are allocates of a few pages and frees of pages
   // that are really held, which drives the table to its limit; the rest are
   // frees of arbitrary pages and allocates of arbitrary size.
   task automatic random_request();
      int pick;
      int sel;
      logic [19:0] page;
      bit skip;
      pick = $urandom_range(0, 99);
      skip = ($urandom_range(0, 2) == 0);
      if (pick < 45) begin
         send_request(OP_ALLOC, ($urandom_range(0, 4) == 0) ? 21'($urandom_range(1, 80))
                                                            : 21'($urandom_range(1, 8)),
                      20'($urandom), skip);
      end else if (pick < 75 && live_pages.size() != 0) begin
         sel = $urandom_range(0, live_pages.size() - 1);
         page = live_pages[sel];
         live_pages.delete(sel);
         send_request(OP_FREE, 21'($urandom), page, skip);
      end else if (pick < 88) begin
         send_request(OP_FREE, 21'($urandom),
                      ($urandom_range(0, 1) == 0) ? 20'($urandom)
                                                  : 20'($urandom_range(0, 300)),
                      skip);
      end else begin
         send_request(OP_ALLOC, ($urandom_range(0, 3) == 0) ? 21'd0 : 21'($urandom),
                      20'($urandom), skip);
      end
      pace_sender();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on the reset pool of 4096 pages with 256 reserved.
      send_request(OP_ALLOC, 21'd0, 20'hFFFFF, 1'b0);          // zero-length request
      send_request(OP_ALLOC, 21'd1, 20'd0, 1'b0);              // grant at page 256
      send_request(OP_ALLOC, 21'h1FFFFF, 20'd0, 1'b1);         // too large, no merge
      send_request(OP_ALLOC, 21'h1FFFFF, 20'd0, 1'b0);         // too large after merge
      send_request(OP_FREE, 21'h1FFFFF, 20'd256, 1'b0);
      send_request(OP_FREE, 21'd0, 20'd256, 1'b1);             // already free
      send_request(OP_FREE, 21'd0, 20'hFFFFF, 1'b0);           // unknown page
      send_request(OP_FREE, 21'd0, 20'd300, 1'b1);             // inside a segment
      send_request(OP_ALLOC, 21'd3840, 20'd0, 1'b1);           // fits only after merge
      send_request(OP_ALLOC, 21'd3840, 20'd0, 1'b0);           // merges, exact fit
      send_request(OP_ALLOC, 21'd1, 20'd0, 1'b0);              // pool exhausted
      send_request(OP_FREE, 21'd0, 20'd256, 1'b0);
      send_request(OP_FREE, 21'd0, 20'd0, 1'b0);               // reserved run freed
      send_request(OP_ALLOC, 21'd4096, 20'd0, 1'b1);
      send_request(OP_ALLOC, 21'd4096, 20'd0, 1'b0);           // whole memory
      req_tvalid <= 1'b0;

      // Fill a tiny pool one page at a time until the table has no room to split.
      set_pool(32'd200, 32'd10);
      repeat (66) send_request(OP_ALLOC, 21'd1, 20'd0, 1'b1);
      req_tvalid <= 1'b0;

      // Random part, over several pool sizes including the clamped extremes.
      set_pool(32'd200, 32'd10);
      repeat (200) random_request();
      set_pool(32'd1048576, 32'd0);
      repeat (130) random_request();
      set_pool(32'h1FFFFF, 32'h1FFFFF);                       // both clamped, no free pages
      repeat (40) random_request();
      set_pool(32'd0, 32'd0);
      repeat (40) random_request();
      set_pool(32'd64, 32'd0);
      repeat (200) random_request();
      set_pool(32'd1000, 32'd1000);
      repeat (40) random_request();
      set_pool(32'd2000000, 32'd12345);
      repeat (130) random_request();
      set_pool(32'd100, 32'd5);
      repeat (220) random_request();
      set_pool(32'd4096, 32'd256);
      repeat (150) random_request();

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/ffpa_pkg.sv
rtl/ffpa_seg_mem.sv
rtl/ffpa_ctrl.sv
rtl/first_fit_page_allocator.sv
rtl/ffpa_checker.sv
tb/sv/ffpa_checker.sv
tb/sv/first_fit_page_allocator_tb.sv
